FILE: design/blr_pkg.sv
// Package for the line rasterizer: widths, codes and request types.
`timescale 1ns / 1ps
package blr_pkg;

    localparam int COORD_BITS = 10;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int COLOR_BITS = 24;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic [COLOR_BITS-1:0]      t_color;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd   cmd;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
        t_color pixel_color;
    } t_line_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color out_color;
        logic   last_pixel;
    } t_pixel;

    // Classified request as held in the queue.
    typedef struct packed {
        t_cmd   cmd;
        logic   steep;
        t_coord major_pos;
        t_coord minor_pos;
        t_coord major_end;
        logic   major_step_neg;
        logic   minor_step_neg;
        t_coord abs_major_delta;
        t_coord abs_minor_delta;
        t_color color;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

FILE: design/blr_if.sv
// Valid/ready channel interfaces for line requests and pixels.
`timescale 1ns / 1ps
interface blr_in_if;
    logic                 valid;
    logic                 ready;
    blr_pkg::t_line_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface blr_out_if;
    logic             valid;
    logic             ready;
    blr_pkg::t_pixel  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/blr_front.sv
// Front end: accepts requests and classifies line octant and deltas.
`timescale 1ns / 1ps
module blr_front (
    blr_in_if.sink         i_req,
    input  logic           i_q_full,
    output logic           o_push,
    output blr_pkg::t_job  o_job
);
    import blr_pkg::*;

    logic   w_xneg;
    logic   w_yneg;
    logic   w_steep;
    t_coord w_adx;
    t_coord w_ady;

    always_comb begin
        w_xneg  = i_req.data.end_x < i_req.data.start_x;
        w_yneg  = i_req.data.end_y < i_req.data.start_y;
        w_adx   = w_xneg ? i_req.data.start_x - i_req.data.end_x
                         : i_req.data.end_x - i_req.data.start_x;
        w_ady   = w_yneg ? i_req.data.start_y - i_req.data.end_y
                         : i_req.data.end_y - i_req.data.start_y;
        w_steep = w_adx < w_ady;

        o_job.cmd   = i_req.data.cmd;
        o_job.steep = w_steep;
        o_job.color = i_req.data.pixel_color;
        if (w_steep) begin
            o_job.major_pos       = i_req.data.start_y;
            o_job.minor_pos       = i_req.data.start_x;
            o_job.major_end       = i_req.data.end_y;
            o_job.major_step_neg  = w_yneg;
            o_job.minor_step_neg  = w_xneg;
            o_job.abs_major_delta = w_ady;
            o_job.abs_minor_delta = w_adx;
        end else begin
            o_job.major_pos       = i_req.data.start_x;
            o_job.minor_pos       = i_req.data.start_y;
            o_job.major_end       = i_req.data.end_x;
            o_job.major_step_neg  = w_xneg;
            o_job.minor_step_neg  = w_yneg;
            o_job.abs_major_delta = w_adx;
            o_job.abs_minor_delta = w_ady;
        end
    end

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

endmodule

FILE: design/blr_queue.sv
// Two-entry queue between the front end and the stepping engine.
`timescale 1ns / 1ps
module blr_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  blr_pkg::t_job        i_job,
    input  logic                 i_pop,
    output blr_pkg::t_job        o_job,
    output blr_pkg::t_q_status   o_status
);
    import blr_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.valid  = r_count != 2'd0;
    assign o_status.full   = r_count == 2'd2;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_status.valid)
        else $error("queue pop while empty");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: design/blr_back.sv
// Stepping engine: holds the active line; at most one pixel per request.
`timescale 1ns / 1ps
module blr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blr_pkg::t_job        i_job,
    input  blr_pkg::t_q_status   i_q_status,
    output logic                 o_pop,
    blr_out_if.source            o_pix
);
    import blr_pkg::*;

    logic   r_line_active;
    logic   r_steep;
    t_coord r_major_pos;
    t_coord r_minor_pos;
    t_coord r_major_end;
    logic   r_major_step_neg;
    logic   r_minor_step_neg;
    t_err   r_error_term;
    t_err   r_inc_keep;
    t_err   r_inc_step;
    t_color r_line_color;
    logic   r_out_valid;
    t_pixel r_out;

    logic   n_line_active;
    logic   n_steep;
    t_coord n_major_pos;
    t_coord n_minor_pos;
    t_coord n_major_end;
    logic   n_major_step_neg;
    logic   n_minor_step_neg;
    t_err   n_error_term;
    t_err   n_inc_keep;
    t_err   n_inc_step;
    t_color n_line_color;
    logic   n_emit;
    logic   n_last;
    t_err   w_minor2;
    t_err   w_major2;

    assign o_pop = i_q_status.valid && (!r_out_valid || o_pix.ready);

    always_comb begin
        n_line_active    = r_line_active;
        n_steep          = r_steep;
        n_major_pos      = r_major_pos;
        n_minor_pos      = r_minor_pos;
        n_major_end      = r_major_end;
        n_major_step_neg = r_major_step_neg;
        n_minor_step_neg = r_minor_step_neg;
        n_error_term     = r_error_term;
        n_inc_keep       = r_inc_keep;
        n_inc_step       = r_inc_step;
        n_line_color     = r_line_color;
        n_emit           = 1'b0;
        n_last           = 1'b0;
        w_minor2         = t_err'({i_job.abs_minor_delta, 1'b0});
        w_major2         = t_err'({i_job.abs_major_delta, 1'b0});

        if (o_pop) begin
            case (i_job.cmd)
                CMD_LOAD: begin
                    n_steep          = i_job.steep;
                    n_major_pos      = i_job.major_pos;
                    n_minor_pos      = i_job.minor_pos;
                    n_major_end      = i_job.major_end;
                    n_major_step_neg = i_job.major_step_neg;
                    n_minor_step_neg = i_job.minor_step_neg;
                    n_line_color     = i_job.color;
                    n_error_term     = w_minor2 - t_err'(i_job.abs_major_delta);
                    n_inc_keep       = w_minor2;
                    n_inc_step       = w_minor2 - w_major2;
                    n_last           = i_job.major_pos == i_job.major_end;
                    n_line_active    = !n_last;
                    n_emit           = 1'b1;
                end
                CMD_ADVANCE: begin
                    if (r_line_active) begin
                        if (r_error_term < 0) begin
                            n_error_term = r_error_term + r_inc_keep;
                        end else begin
                            n_error_term = r_error_term + r_inc_step;
                            n_minor_pos  = r_minor_step_neg ? r_minor_pos - t_coord'(1)
                                                            : r_minor_pos + t_coord'(1);
                        end
                        n_major_pos   = r_major_step_neg ? r_major_pos - t_coord'(1)
                                                         : r_major_pos + t_coord'(1);
                        n_last        = n_major_pos == r_major_end;
                        n_line_active = !n_last;
                        n_emit        = 1'b1;
                    end
                end
                default: begin
                    n_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
            if (o_pop) begin
                r_out_valid <= n_emit;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_steep          <= n_steep;
        r_major_pos      <= n_major_pos;
        r_minor_pos      <= n_minor_pos;
        r_major_end      <= n_major_end;
        r_major_step_neg <= n_major_step_neg;
        r_minor_step_neg <= n_minor_step_neg;
        r_error_term     <= n_error_term;
        r_inc_keep       <= n_inc_keep;
        r_inc_step       <= n_inc_step;
        r_line_color     <= n_line_color;
        if (o_pop && n_emit) begin
            r_out.pixel_x    <= n_steep ? n_minor_pos : n_major_pos;
            r_out.pixel_y    <= n_steep ? n_major_pos : n_minor_pos;
            r_out.out_color  <= n_line_color;
            r_out.last_pixel <= n_last;
        end
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out;

`ifndef SYNTHESIS
    a_active_not_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_major_pos != r_major_end))
        else $error("active line already at its end");
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_emit && n_last) |=> !r_line_active)
        else $error("line still active after last pixel");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready) |-> !o_pop)
        else $error("pending pixel overwritten");
`endif

endmodule

FILE: design/bresenham_line_rasterizer.sv
// Top level of the line rasterizer: front end, queue and stepping engine.
// An accepted request is written to the queue, then popped into the pixel register.
// One request per cycle unless the queue is full; one error update per popped request.
// A two-entry queue lets the front accept while a finished pixel waits on the output.
// Reset (synchronous, active low) empties the queue and output and idles the line.
`timescale 1ns / 1ps
module bresenham_line_rasterizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blr_in_if.sink     i_req,
    blr_out_if.source  o_pix
);
    import blr_pkg::*;

    t_job      w_push_job;
    t_job      w_head_job;
    logic      w_push;
    logic      w_pop;
    t_q_status w_q_status;

    blr_front u_front (
        .i_req    (i_req),
        .i_q_full (w_q_status.full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    blr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    blr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_head_job),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_pix      (o_pix)
    );

endmodule
